@@ rtl/pcf_pkg.sv @@
// Package for the polyline crossing finder: widths, command codes, the queued
// item type and the interval test used by the pair engine.
// No dependencies.
package pcf_pkg;

   localparam int COORD_W        = 32;
   localparam int DIFF_W         = COORD_W + 1;
   localparam int PROD_W         = 2 * DIFF_W;
   localparam int WIDE_W         = PROD_W + 1;
   localparam int MAG_W          = WIDE_W - 1;
   localparam int QUEUE_DEPTH    = 4;
   localparam int DEF_MAX_POINTS = 64;
   localparam int DEF_MAX_HITS   = 64;

   typedef enum logic [1:0] {
      CMD_LOAD_FIRST  = 2'd0,
      CMD_LOAD_SECOND = 2'd1,
      CMD_COMPUTE     = 2'd2,
      CMD_CLEAR       = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                    command;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_y;
      logic                       point_set;
   } item_type;

   // True when n / den lies in [0, 1]; den is known to be non-zero.
   function automatic logic in_unit(input logic signed [WIDE_W-1:0] n,
                                    input logic signed [WIDE_W-1:0] den);
      logic res;
      if (den < 0) begin
         res = (n >= den) && (n <= 0);
      end else begin
         res = (n >= 0) && (n <= den);
      end
      return res;
   endfunction

endpackage

@@ rtl/pcf_front.sv @@
// Front part of the polyline crossing finder: takes items from the request
// channel, decodes the command and holds them in a short queue.
// Depends on pcf_pkg.
module pcf_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [1:0]                  req_command,
   input  logic signed [31:0]          req_coord_x,
   input  logic signed [31:0]          req_coord_y,
   input  logic                        req_point_set,
   output logic                        item_valid,
   output pcf_pkg::item_type           item,
   input  logic                        item_pop
);
   import pcf_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   item_type           queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W:0]     count_ff;
   logic               do_push;
   logic               do_pop;
   item_type           decoded;

   always_comb begin
      decoded.command   = cmd_type'(req_command);
      decoded.coord_x   = req_coord_x;
      decoded.coord_y   = req_coord_y;
      decoded.point_set = req_point_set;
   end

   assign req_full   = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];
   assign do_push    = req_push && !req_full;
   assign do_pop     = item_pop && item_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

@@ rtl/pcf_muldiv.sv @@
// Serial multiply-then-divide unit: floor(num * mult / den) on magnitudes,
// one shift-add step per cycle, then one restoring division step per cycle.
// Depends on pcf_pkg.
module pcf_muldiv (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [pcf_pkg::MAG_W-1:0]         num_mag,
   input  logic [pcf_pkg::MAG_W-1:0]         den_mag,
   input  logic [pcf_pkg::COORD_W-1:0]       mult_mag,
   output logic                              done,
   output logic [pcf_pkg::COORD_W-1:0]       quot,
   output logic                              rem_nz
);
   import pcf_pkg::*;

   localparam int ACC_W = MAG_W + COORD_W;
   localparam int CNT_W = $clog2(COORD_W);

   typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_type;

   md_state_type        state_ff;
   logic [CNT_W-1:0]    step_ff;
   logic [MAG_W-1:0]    num_ff;
   logic [MAG_W-1:0]    den_ff;
   logic [COORD_W-1:0]  mult_ff;
   logic [MAG_W-1:0]    rem_ff;
   logic [COORD_W-1:0]  low_ff;
   logic                done_ff;
   logic [ACC_W-1:0]    acc_in;
   logic [MAG_W:0]      trial;
   logic [MAG_W:0]      diff;

   // The product lives in {rem_ff, low_ff}; the division then shifts quotient
   // bits into low_ff as the dividend bits leave it.
   always_comb begin
      acc_in = {rem_ff[MAG_W-2:0], low_ff, 1'b0}
               + (mult_ff[COORD_W-1] ? {{COORD_W{1'b0}}, num_ff} : '0);
      trial  = {rem_ff, low_ff[COORD_W-1]};
      diff   = trial - {1'b0, den_ff};
   end

   assign done   = done_ff;
   assign quot   = low_ff;
   assign rem_nz = |rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            MD_IDLE: begin
               done_ff <= 1'b0;
               if (start) begin
                  num_ff   <= num_mag;
                  den_ff   <= den_mag;
                  mult_ff  <= mult_mag;
                  rem_ff   <= '0;
                  low_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= MD_MUL;
               end
            end
            MD_MUL: begin
               done_ff <= 1'b0;
               {rem_ff, low_ff} <= acc_in;
               mult_ff <= {mult_ff[COORD_W-2:0], 1'b0};
               // The step count wraps to zero after the last step.
               step_ff <= step_ff + 1'b1;
               if (step_ff == CNT_W'(COORD_W - 1)) begin
                  state_ff <= MD_DIV;
               end
            end
            MD_DIV: begin
               if (!diff[MAG_W]) begin
                  rem_ff <= diff[MAG_W-1:0];
                  low_ff <= {low_ff[COORD_W-2:0], 1'b1};
               end else begin
                  rem_ff <= trial[MAG_W-1:0];
                  low_ff <= {low_ff[COORD_W-2:0], 1'b0};
               end
               step_ff <= step_ff + 1'b1;
               done_ff <= (step_ff == CNT_W'(COORD_W - 1));
               if (step_ff == CNT_W'(COORD_W - 1)) begin
                  state_ff <= MD_IDLE;
               end
            end
            default: begin
               done_ff  <= 1'b0;
               state_ff <= MD_IDLE;
            end
         endcase
      end
   end

endmodule

@@ rtl/pcf_back.sv @@
// Back part of the polyline crossing finder: point stores, the segment pair
// walk with its shared multiplier, hit list with duplicate scan, result register.
// Depends on pcf_pkg and pcf_muldiv.
module pcf_back #(
   parameter int MAX_POINTS = pcf_pkg::DEF_MAX_POINTS,
   parameter int MAX_HITS   = pcf_pkg::DEF_MAX_HITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  pcf_pkg::item_type     item,
   output logic                  item_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic signed [31:0]    rsp_hit_x,
   output logic signed [31:0]    rsp_hit_y,
   output logic                  rsp_hit_valid,
   output logic                  rsp_last,
   output logic                  rsp_truncated
);
   import pcf_pkg::*;

   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int CNT_W  = IDX_W + 1;
   localparam int HIDX_W = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
   localparam int HCNT_W = HIDX_W + 1;

   typedef struct packed {
      logic                present;
      logic [COORD_W-1:0]  y;
      logic [COORD_W-1:0]  x;
   } point_type;

   typedef enum logic [4:0] {
      S_IDLE, S_F_RD, S_F_USE, S_S_RD, S_S_USE, S_MUL, S_TEST1, S_TEST2,
      S_DIV_GO, S_DIV_WAIT, S_D_RD, S_D_CMP, S_INSERT, S_NEXT, S_E_START, S_E_RD,
      S_E_WR
   } state_type;

   point_type             first_mem  [MAX_POINTS];
   point_type             second_mem [MAX_POINTS];
   logic [2*COORD_W-1:0]  found_mem  [MAX_HITS];

   state_type                   state_ff;
   logic [CNT_W-1:0]            first_count_ff;
   logic [CNT_W-1:0]            second_count_ff;
   logic [HCNT_W-1:0]           found_count_ff;
   logic                        overflow_ff;
   logic [IDX_W-1:0]            fi_ff;
   logic [IDX_W-1:0]            sj_ff;
   logic [HIDX_W-1:0]           hk_ff;
   logic [2:0]                  mstep_ff;
   point_type                   first_rd_ff;
   point_type                   second_rd_ff;
   logic [2*COORD_W-1:0]        found_rd_ff;
   point_type                   prev1_ff;
   point_type                   prev2_ff;
   logic signed [COORD_W-1:0]   x1_ff;
   logic signed [COORD_W-1:0]   y1_ff;
   logic signed [DIFF_W-1:0]    dx1_ff;
   logic signed [DIFF_W-1:0]    dy1_ff;
   logic signed [DIFF_W-1:0]    dx2_ff;
   logic signed [DIFF_W-1:0]    dy2_ff;
   logic signed [DIFF_W-1:0]    ay_ff;
   logic signed [DIFF_W-1:0]    ax_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [WIDE_W-1:0]    den_ff;
   logic signed [WIDE_W-1:0]    n1_ff;
   logic signed [WIDE_W-1:0]    n2_ff;
   logic [MAG_W-1:0]            n1_mag_ff;
   logic [MAG_W-1:0]            den_mag_ff;
   logic [COORD_W-1:0]          dx1_mag_ff;
   logic [COORD_W-1:0]          dy1_mag_ff;
   logic                        negx_ff;
   logic                        negy_ff;
   logic [COORD_W-1:0]          hit_x_ff;
   logic [COORD_W-1:0]          hit_y_ff;
   logic                        out_valid_ff;
   logic [COORD_W-1:0]          out_x_ff;
   logic [COORD_W-1:0]          out_y_ff;
   logic                        out_hit_ff;
   logic                        out_last_ff;
   logic                        out_trunc_ff;

   logic signed [DIFF_W-1:0]    op_a;
   logic signed [DIFF_W-1:0]    op_b;
   logic signed [DIFF_W-1:0]    cur1_dx;
   logic signed [DIFF_W-1:0]    cur1_dy;
   logic signed [DIFF_W-1:0]    cur2_dx;
   logic signed [DIFF_W-1:0]    cur2_dy;
   logic                        inner_last;
   logic                        outer_last;
   logic                        hk_last;
   logic                        out_free;
   logic                        out_load;
   logic                        md_start;
   logic                        mdx_done;
   logic                        mdy_done;
   logic [COORD_W-1:0]          qx;
   logic [COORD_W-1:0]          qy;
   logic                        rnzx;
   logic                        rnzy;
   logic [COORD_W-1:0]          vx;
   logic [COORD_W-1:0]          vy;
   logic                        first_we;
   logic                        second_we;
   logic                        found_we;

   function automatic logic [MAG_W-1:0] wide_abs(input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-1:0] m;
      m = (v < 0) ? WIDE_W'(-v) : WIDE_W'(v);
      return m[MAG_W-1:0];
   endfunction

   function automatic logic [COORD_W-1:0] diff_abs(input logic signed [DIFF_W-1:0] v);
      logic [DIFF_W-1:0] m;
      m = (v < 0) ? DIFF_W'(-v) : DIFF_W'(v);
      return m[COORD_W-1:0];
   endfunction

   always_comb begin
      cur1_dx = {first_rd_ff.x[COORD_W-1], first_rd_ff.x} - {prev1_ff.x[COORD_W-1], prev1_ff.x};
      cur1_dy = {first_rd_ff.y[COORD_W-1], first_rd_ff.y} - {prev1_ff.y[COORD_W-1], prev1_ff.y};
      cur2_dx = {second_rd_ff.x[COORD_W-1], second_rd_ff.x}
                - {prev2_ff.x[COORD_W-1], prev2_ff.x};
      cur2_dy = {second_rd_ff.y[COORD_W-1], second_rd_ff.y}
                - {prev2_ff.y[COORD_W-1], prev2_ff.y};
   end

   // Operand order for the six products: den takes the first two, n1 the next
   // two and n2 the last two.
   always_comb begin
      case (mstep_ff)
         3'd0:    begin op_a = dy1_ff; op_b = dx2_ff; end
         3'd1:    begin op_a = dy2_ff; op_b = dx1_ff; end
         3'd2:    begin op_a = dx2_ff; op_b = ay_ff;  end
         3'd3:    begin op_a = dy2_ff; op_b = ax_ff;  end
         3'd4:    begin op_a = dx1_ff; op_b = ay_ff;  end
         3'd5:    begin op_a = dy1_ff; op_b = ax_ff;  end
         default: begin op_a = '0;     op_b = '0;     end
      endcase
   end

   assign inner_last = (({1'b0, sj_ff} + 1'b1) == second_count_ff);
   assign outer_last = (({1'b0, fi_ff} + 1'b1) == first_count_ff);
   assign hk_last    = (({1'b0, hk_ff} + 1'b1) == found_count_ff);
   assign out_free   = !out_valid_ff || rsp_pop;
   assign out_load   = ((state_ff == S_E_START) && (found_count_ff == '0) && out_free)
                       || (state_ff == S_E_WR);
   assign item_pop   = (state_ff == S_IDLE) && item_valid;
   assign md_start   = (state_ff == S_DIV_GO);

   assign first_we  = item_pop && (item.command == CMD_LOAD_FIRST)
                      && (first_count_ff < CNT_W'(MAX_POINTS));
   assign second_we = item_pop && (item.command == CMD_LOAD_SECOND)
                      && (second_count_ff < CNT_W'(MAX_POINTS));
   assign found_we  = (state_ff == S_INSERT) && (found_count_ff < HCNT_W'(MAX_HITS));

   // A negative offset is floored: -q when the division is exact, else -q-1.
   assign vx = negx_ff ? (~qx + {{(COORD_W-1){1'b0}}, ~rnzx}) : qx;
   assign vy = negy_ff ? (~qy + {{(COORD_W-1){1'b0}}, ~rnzy}) : qy;

   pcf_muldiv u_muldiv_x (
      .clock    (clock),
      .reset    (reset),
      .start    (md_start),
      .num_mag  (n1_mag_ff),
      .den_mag  (den_mag_ff),
      .mult_mag (dx1_mag_ff),
      .done     (mdx_done),
      .quot     (qx),
      .rem_nz   (rnzx)
   );

   pcf_muldiv u_muldiv_y (
      .clock    (clock),
      .reset    (reset),
      .start    (md_start),
      .num_mag  (n1_mag_ff),
      .den_mag  (den_mag_ff),
      .mult_mag (dy1_mag_ff),
      .done     (mdy_done),
      .quot     (qy),
      .rem_nz   (rnzy)
   );

   always_ff @(posedge clock) begin
      if (first_we) begin
         first_mem[first_count_ff[IDX_W-1:0]] <= {item.point_set, item.coord_y, item.coord_x};
      end
      if (state_ff == S_F_RD) begin
         first_rd_ff <= first_mem[fi_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (second_we) begin
         second_mem[second_count_ff[IDX_W-1:0]] <= {item.point_set, item.coord_y, item.coord_x};
      end
      if (state_ff == S_S_RD) begin
         second_rd_ff <= second_mem[sj_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (found_we) begin
         found_mem[found_count_ff[HIDX_W-1:0]] <= {hit_y_ff, hit_x_ff};
      end
      if ((state_ff == S_D_RD) || ((state_ff == S_E_RD) && out_free)) begin
         found_rd_ff <= found_mem[hk_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         found_count_ff  <= '0;
         overflow_ff     <= 1'b0;
         fi_ff           <= '0;
         sj_ff           <= '0;
         hk_ff           <= '0;
         mstep_ff        <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  case (item.command)
                     CMD_LOAD_FIRST: begin
                        if (first_we) begin
                           first_count_ff <= first_count_ff + 1'b1;
                        end else begin
                           overflow_ff <= 1'b1;
                        end
                     end
                     CMD_LOAD_SECOND: begin
                        if (second_we) begin
                           second_count_ff <= second_count_ff + 1'b1;
                        end else begin
                           overflow_ff <= 1'b1;
                        end
                     end
                     CMD_CLEAR: begin
                        first_count_ff  <= '0;
                        second_count_ff <= '0;
                        found_count_ff  <= '0;
                        overflow_ff     <= 1'b0;
                     end
                     default: begin
                        found_count_ff <= '0;
                        fi_ff          <= '0;
                        // Either curve without a segment means no pair to test.
                        if ((first_count_ff >= CNT_W'(2)) && (second_count_ff >= CNT_W'(2))) begin
                           state_ff <= S_F_RD;
                        end else begin
                           state_ff <= S_E_START;
                        end
                     end
                  endcase
               end
            end
            S_F_RD: begin
               state_ff <= S_F_USE;
            end
            S_F_USE: begin
               prev1_ff <= first_rd_ff;
               if ((fi_ff != '0) && prev1_ff.present && first_rd_ff.present) begin
                  x1_ff    <= prev1_ff.x;
                  y1_ff    <= prev1_ff.y;
                  dx1_ff   <= cur1_dx;
                  dy1_ff   <= cur1_dy;
                  sj_ff    <= '0;
                  state_ff <= S_S_RD;
               end else if (outer_last) begin
                  state_ff <= S_E_START;
               end else begin
                  fi_ff    <= fi_ff + 1'b1;
                  state_ff <= S_F_RD;
               end
            end
            S_S_RD: begin
               state_ff <= S_S_USE;
            end
            S_S_USE: begin
               prev2_ff <= second_rd_ff;
               if ((sj_ff != '0) && prev2_ff.present && second_rd_ff.present) begin
                  dx2_ff   <= cur2_dx;
                  dy2_ff   <= cur2_dy;
                  ay_ff    <= {prev2_ff.y[COORD_W-1], prev2_ff.y} - {y1_ff[COORD_W-1], y1_ff};
                  ax_ff    <= {x1_ff[COORD_W-1], x1_ff} - {prev2_ff.x[COORD_W-1], prev2_ff.x};
                  mstep_ff <= '0;
                  state_ff <= S_MUL;
               end else if (inner_last) begin
                  sj_ff <= '0;
                  if (outer_last) begin
                     state_ff <= S_E_START;
                  end else begin
                     fi_ff    <= fi_ff + 1'b1;
                     state_ff <= S_F_RD;
                  end
               end else begin
                  sj_ff    <= sj_ff + 1'b1;
                  state_ff <= S_S_RD;
               end
            end
            S_MUL: begin
               prod_ff  <= op_a * op_b;
               mstep_ff <= mstep_ff + 1'b1;
               case (mstep_ff)
                  3'd1:    den_ff <= {prod_ff[PROD_W-1], prod_ff};
                  3'd2:    den_ff <= den_ff - {prod_ff[PROD_W-1], prod_ff};
                  3'd3:    n1_ff  <= {prod_ff[PROD_W-1], prod_ff};
                  3'd4:    n1_ff  <= n1_ff + {prod_ff[PROD_W-1], prod_ff};
                  3'd5:    n2_ff  <= {prod_ff[PROD_W-1], prod_ff};
                  3'd6: begin
                     n2_ff    <= n2_ff + {prod_ff[PROD_W-1], prod_ff};
                     state_ff <= S_TEST1;
                  end
                  default: den_ff <= den_ff;
               endcase
            end
            S_TEST1: begin
               n1_mag_ff  <= wide_abs(n1_ff);
               den_mag_ff <= wide_abs(den_ff);
               if ((den_ff != '0) && in_unit(n1_ff, den_ff)) begin
                  state_ff <= S_TEST2;
               end else begin
                  state_ff <= S_NEXT;
               end
            end
            S_TEST2: begin
               dx1_mag_ff <= diff_abs(dx1_ff);
               dy1_mag_ff <= diff_abs(dy1_ff);
               negx_ff    <= n1_ff[WIDE_W-1] ^ den_ff[WIDE_W-1] ^ dx1_ff[DIFF_W-1];
               negy_ff    <= n1_ff[WIDE_W-1] ^ den_ff[WIDE_W-1] ^ dy1_ff[DIFF_W-1];
               if (in_unit(n2_ff, den_ff)) begin
                  state_ff <= S_DIV_GO;
               end else begin
                  state_ff <= S_NEXT;
               end
            end
            S_DIV_GO: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (mdx_done && mdy_done) begin
                  hit_x_ff <= x1_ff + vx;
                  hit_y_ff <= y1_ff + vy;
                  hk_ff    <= '0;
                  if (found_count_ff == '0) begin
                     state_ff <= S_INSERT;
                  end else begin
                     state_ff <= S_D_RD;
                  end
               end
            end
            S_D_RD: begin
               state_ff <= S_D_CMP;
            end
            S_D_CMP: begin
               if (found_rd_ff == {hit_y_ff, hit_x_ff}) begin
                  state_ff <= S_NEXT;
               end else if (hk_last) begin
                  state_ff <= S_INSERT;
               end else begin
                  hk_ff    <= hk_ff + 1'b1;
                  state_ff <= S_D_RD;
               end
            end
            S_INSERT: begin
               if (found_we) begin
                  found_count_ff <= found_count_ff + 1'b1;
               end else begin
                  overflow_ff <= 1'b1;
               end
               state_ff <= S_NEXT;
            end
            // The pair is finished: move to the next second-curve point, or
            // to the next first-curve point when the inner walk is done.
            S_NEXT: begin
               if (inner_last) begin
                  sj_ff <= '0;
                  if (outer_last) begin
                     state_ff <= S_E_START;
                  end else begin
                     fi_ff    <= fi_ff + 1'b1;
                     state_ff <= S_F_RD;
                  end
               end else begin
                  sj_ff    <= sj_ff + 1'b1;
                  state_ff <= S_S_RD;
               end
            end
            S_E_START: begin
               hk_ff <= '0;
               if (found_count_ff != '0) begin
                  state_ff <= S_E_RD;
               end else if (out_free) begin
                  out_x_ff     <= '0;
                  out_y_ff     <= '0;
                  out_hit_ff   <= 1'b0;
                  out_last_ff  <= 1'b1;
                  out_trunc_ff <= overflow_ff;
                  state_ff     <= S_IDLE;
               end
            end
            S_E_RD: begin
               if (out_free) begin
                  state_ff <= S_E_WR;
               end
            end
            S_E_WR: begin
               out_x_ff     <= found_rd_ff[COORD_W-1:0];
               out_y_ff     <= found_rd_ff[2*COORD_W-1:COORD_W];
               out_hit_ff   <= 1'b1;
               out_last_ff  <= hk_last;
               out_trunc_ff <= overflow_ff;
               if (hk_last) begin
                  state_ff <= S_IDLE;
               end else begin
                  hk_ff    <= hk_ff + 1'b1;
                  state_ff <= S_E_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_hit_x     = out_x_ff;
   assign rsp_hit_y     = out_y_ff;
   assign rsp_hit_valid = out_hit_ff;
   assign rsp_last      = out_last_ff;
   assign rsp_truncated = out_trunc_ff;

endmodule

@@ rtl/polyline_crossing_finder.sv @@
// Top level of the polyline crossing finder: request queue in front of the
// pair engine.
// Depends on pcf_pkg, pcf_front and pcf_back.
//
//   channel   handshake         payload
//   req       req_push/full     command, coord_x, coord_y, point_set
//   rsp       rsp_pop/empty     hit_x, hit_y, hit_valid, last, truncated
//
// Loads and clears are taken one per cycle from a four-entry queue while no
// compute runs. A compute walks every segment pair, reading points from the
// stores and forming the products for each pair tested; each crossing found
// takes a serial multiply and divide and a duplicate scan over the hit list.
// Results then leave one at a time. Reset is synchronous and empties both
// curves and the hit list; a stalled result holds the engine only.
module polyline_crossing_finder #(
   parameter int MAX_POINTS = pcf_pkg::DEF_MAX_POINTS,
   parameter int MAX_HITS   = pcf_pkg::DEF_MAX_HITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [1:0]          req_command,
   input  logic signed [31:0]  req_coord_x,
   input  logic signed [31:0]  req_coord_y,
   input  logic                req_point_set,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic signed [31:0]  rsp_hit_x,
   output logic signed [31:0]  rsp_hit_y,
   output logic                rsp_hit_valid,
   output logic                rsp_last,
   output logic                rsp_truncated
);
   import pcf_pkg::*;

   logic      item_valid;
   item_type  item;
   logic      item_pop;

   pcf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_command   (req_command),
      .req_coord_x   (req_coord_x),
      .req_coord_y   (req_coord_y),
      .req_point_set (req_point_set),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop)
   );

   pcf_back #(
      .MAX_POINTS (MAX_POINTS),
      .MAX_HITS   (MAX_HITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_hit_x     (rsp_hit_x),
      .rsp_hit_y     (rsp_hit_y),
      .rsp_hit_valid (rsp_hit_valid),
      .rsp_last      (rsp_last),
      .rsp_truncated (rsp_truncated)
   );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for polyline_crossing_finder: directed and random
// command streams, checked against an in-bench crossing predictor.
// Depends on pcf_pkg and the polyline_crossing_finder RTL.
module tb_top;
   import pcf_pkg::*;

   localparam int CURVE_DEPTH = 64;
   localparam int HIT_DEPTH   = 64;
   localparam int CYCLE_LIMIT = 3000000;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic signed [31:0] hit_x;
      logic signed [31:0] hit_y;
      logic               hit_valid;
      logic               last;
      logic               truncated;
   } crossing_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [1:0]         req_command = CMD_CLEAR;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic               req_point_set = 1'b0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic signed [31:0] rsp_hit_x;
   logic signed [31:0] rsp_hit_y;
   logic               rsp_hit_valid;
   logic               rsp_last;
   logic               rsp_truncated;

   // Predictor state
   logic signed [31:0] curve_x [2][CURVE_DEPTH];
   logic signed [31:0] curve_y [2][CURVE_DEPTH];
   logic               curve_set [2][CURVE_DEPTH];
   int                 curve_len [2];
   logic signed [31:0] seen_x [HIT_DEPTH];
   logic signed [31:0] seen_y [HIT_DEPTH];
   int                 seen_count;
   logic               lost_any;

   crossing_type       pending_crossings[$];
   int                 error_count = 0;
   int                 items_sent = 0;
   int                 cycle_count = 0;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   int                 recv_hold_cycles = 0;

   polyline_crossing_finder u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_command(req_command),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .req_point_set(req_point_set),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_hit_x(rsp_hit_x), .rsp_hit_y(rsp_hit_y), .rsp_hit_valid(rsp_hit_valid),
      .rsp_last(rsp_last), .rsp_truncated(rsp_truncated)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic ratio_in_unit(wide_type n, wide_type den);
      if (den < 0) begin
         return (n >= den) && (n <= 0);
      end
      return (n >= 0) && (n <= den);
   endfunction

   // floor(n * d / den), rounded toward minus infinity
   function automatic wide_type floor_share(wide_type n, wide_type den, wide_type d);
      wide_type num;
      wide_type q;
      num = n * d;
      q = num / den;
      if ((num % den != 0) && ((num < 0) != (den < 0))) begin
         q = q - 1;
      end
      return q;
   endfunction

   function automatic void note_crossing(logic signed [31:0] hx, logic signed [31:0] hy);
      for (int f = 0; f < seen_count; f++) begin
         if (seen_x[f] == hx && seen_y[f] == hy) return;
      end
      if (seen_count < HIT_DEPTH) begin
         seen_x[seen_count] = hx;
         seen_y[seen_count] = hy;
         seen_count++;
      end else begin
         lost_any = 1'b1;
      end
   endfunction

   function automatic void find_crossings();
      wide_type x1, y1, dx1, dy1, x2, y2, dx2, dy2, den, n1, n2, hx, hy;
      crossing_type c;
      seen_count = 0;
      for (int i = 1; i < curve_len[0]; i++) begin
         if (!curve_set[0][i-1] || !curve_set[0][i]) continue;
         x1 = curve_x[0][i-1];
         y1 = curve_y[0][i-1];
         dx1 = wide_type'(curve_x[0][i]) - x1;
         dy1 = wide_type'(curve_y[0][i]) - y1;
         for (int j = 1; j < curve_len[1]; j++) begin
            if (!curve_set[1][j-1] || !curve_set[1][j]) continue;
            x2 = curve_x[1][j-1];
            y2 = curve_y[1][j-1];
            dx2 = wide_type'(curve_x[1][j]) - x2;
            dy2 = wide_type'(curve_y[1][j]) - y2;
            den = dy1 * dx2 - dy2 * dx1;
            if (den == 0) continue;
            n1 = dx2 * (y2 - y1) + dy2 * (x1 - x2);
            n2 = dx1 * (y2 - y1) + dy1 * (x1 - x2);
            if (ratio_in_unit(n1, den) && ratio_in_unit(n2, den)) begin
               hx = x1 + floor_share(n1, den, dx1);
               hy = y1 + floor_share(n1, den, dy1);
               note_crossing(hx[31:0], hy[31:0]);
            end
         end
      end
      if (seen_count == 0) begin
         c = '{0, 0, 1'b0, 1'b1, lost_any};
         pending_crossings.insert(pending_crossings.size(), c);
      end
      for (int k = 0; k < seen_count; k++) begin
         c = '{seen_x[k], seen_y[k], 1'b1, k == seen_count - 1, lost_any};
         pending_crossings.insert(pending_crossings.size(), c);
      end
   endfunction

   function automatic void apply_command(cmd_type cmd, logic signed [31:0] x,
                                         logic signed [31:0] y, logic set);
      int side;
      case (cmd) inside
         CMD_LOAD_FIRST, CMD_LOAD_SECOND: begin
            side = (cmd == CMD_LOAD_FIRST) ? 0 : 1;
            if (curve_len[side] >= CURVE_DEPTH) begin
               lost_any = 1'b1;
            end else begin
               curve_x[side][curve_len[side]] = x;
               curve_y[side][curve_len[side]] = y;
               curve_set[side][curve_len[side]] = set;
               curve_len[side]++;
            end
         end
         CMD_CLEAR: begin
            curve_len[0] = 0;
            curve_len[1] = 0;
            seen_count = 0;
            lost_any = 1'b0;
         end
         default: find_crossings();
      endcase
   endfunction

   // Sends one item; push stays high until the next falling edge.
   task automatic send_item(cmd_type cmd, logic signed [31:0] x, logic signed [31:0] y,
                            logic set);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push = 1'b1;
      req_command = cmd;
      req_coord_x = x;
      req_coord_y = y;
      req_point_set = set;
      do @(posedge clock); while (req_full);
      apply_command(cmd, x, y, set);
      items_sent++;
   endtask

   task automatic load_point(cmd_type cmd, int xi, int yi, logic set = 1'b1);
      send_item(cmd, xi <<< 16, yi <<< 16, set);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_push = 1'b0;
      wait (pending_crossings.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic report_mismatch(string field, logic signed [31:0] got,
                                  logic signed [31:0] want);
      $display("mismatch on %s at cycle %0d: got %0h, expected %0h",
               field, cycle_count, got, want);
      error_count++;
   endtask

   // Result receiver and checker
   initial begin
      crossing_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (pending_crossings.size() == 0) begin
               $display("unexpected result at cycle %0d", cycle_count);
               error_count++;
            end else begin
               want = pending_crossings.pop_front();
               if (rsp_hit_x !== want.hit_x) report_mismatch("hit_x", rsp_hit_x, want.hit_x);
               if (rsp_hit_y !== want.hit_y) report_mismatch("hit_y", rsp_hit_y, want.hit_y);
               if (rsp_hit_valid !== want.hit_valid)
                  report_mismatch("hit_valid", rsp_hit_valid, want.hit_valid);
               if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
               if (rsp_truncated !== want.truncated)
                  report_mismatch("truncated", rsp_truncated, want.truncated);
            end
         end
         @(negedge clock);
         if (recv_hold_cycles > 0) begin
            recv_hold_cycles--;
            rsp_pop = 1'b0;
         end else begin
            rsp_pop = !reset && ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic test_directed();
      send_item(CMD_COMPUTE, 0, 0, 1'b1);
      // Extreme corners: the two diagonals of the full coordinate range
      send_item(CMD_LOAD_FIRST, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
      send_item(CMD_LOAD_FIRST, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
      send_item(CMD_LOAD_SECOND, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
      send_item(CMD_LOAD_SECOND, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
      send_item(CMD_COMPUTE, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
      send_item(CMD_CLEAR, 32'shffff_ffff, 32'shffff_ffff, 1'b1);
      // Parallel segments give no crossing
      load_point(CMD_LOAD_FIRST, 0, 0);
      load_point(CMD_LOAD_FIRST, 4, 0);
      load_point(CMD_LOAD_SECOND, 0, 1);
      load_point(CMD_LOAD_SECOND, 4, 1);
      send_item(CMD_COMPUTE, 0, 0, 1'b1);
      send_item(CMD_CLEAR, 0, 0, 1'b0);
      // A shared vertex on the second curve is found twice and kept once;
      // a gap point and a zero-length segment add nothing.
      load_point(CMD_LOAD_FIRST, 0, 0);
      load_point(CMD_LOAD_FIRST, 10, 0);
      load_point(CMD_LOAD_FIRST, 10, 0);
      load_point(CMD_LOAD_SECOND, 2, -5);
      load_point(CMD_LOAD_SECOND, 5, 0);
      load_point(CMD_LOAD_SECOND, 8, -5);
      load_point(CMD_LOAD_SECOND, 8, 5, 1'b0);
      load_point(CMD_LOAD_SECOND, 9, -5);
      send_item(CMD_COMPUTE, 0, 0, 1'b1);
      wait_drained();
   endtask

   task automatic test_point_overflow();
      send_item(CMD_CLEAR, 0, 0, 1'b1);
      for (int k = 0; k <= CURVE_DEPTH; k++) begin
         load_point(CMD_LOAD_FIRST, k - 32, (k % 2 == 0) ? -3 : 3);
      end
      load_point(CMD_LOAD_SECOND, -40, 1);
      load_point(CMD_LOAD_SECOND, -20, -1);
      send_item(CMD_COMPUTE, 0, 0, 1'b1);
      // The flag stays set on a second compute of the same curves.
      send_item(CMD_COMPUTE, 0, 0, 1'b1);
      wait_drained();
   endtask

   // A zigzag against eight horizontal runs gives eighty distinct crossings.
   task automatic test_hit_overflow();
      send_item(CMD_CLEAR, 0, 0, 1'b1);
      for (int k = 0; k <= 10; k++) begin
         load_point(CMD_LOAD_FIRST, k * 10, (k % 2 == 1) ? 10 : -10);
      end
      for (int m = 0; m < 8; m++) begin
         send_item(CMD_LOAD_SECOND, (m % 2 == 0) ? -50 <<< 16 : 150 <<< 16,
                   ((2 * m - 7) <<< 16) + 32'sh8000, 1'b1);
         send_item(CMD_LOAD_SECOND, (m % 2 == 0) ? 150 <<< 16 : -50 <<< 16,
                   ((2 * m - 7) <<< 16) + 32'sh8000, 1'b1);
      end
      send_item(CMD_COMPUTE, 0, 0, 1'b1);
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_item(CMD_CLEAR, 0, 0, 1'b1);
      load_point(CMD_LOAD_FIRST, -3, -3);
      load_point(CMD_LOAD_FIRST, 3, 3);
      load_point(CMD_LOAD_SECOND, -3, 3);
      load_point(CMD_LOAD_SECOND, 3, -3);
      recv_hold_cycles = 600;
      for (int k = 0; k < 7; k++) begin
         send_item(CMD_COMPUTE, 0, 0, 1'b1);
      end
      wait_drained();
   endtask

   function automatic logic signed [31:0] rand_coord(logic wide_range);
      if (wide_range) return $urandom;
      return ($urandom_range(16) - 8) * 65536 + $urandom_range(65535);
   endfunction

   task automatic test_random(int item_goal);
      int n1, n2;
      logic wide_range;
      while (items_sent < item_goal) begin
         if ($urandom_range(99) < 80) begin
            wide_range = ($urandom_range(9) == 0);
            n1 = $urandom_range(6, 2);
            n2 = $urandom_range(6, 2);
            if ($urandom_range(3) != 0) send_item(CMD_CLEAR, $urandom, $urandom, 1'($urandom));
            for (int k = 0; k < n1; k++)
               send_item(CMD_LOAD_FIRST, rand_coord(wide_range), rand_coord(wide_range),
                         $urandom_range(9) != 0);
            for (int k = 0; k < n2; k++)
               send_item(CMD_LOAD_SECOND, rand_coord(wide_range), rand_coord(wide_range),
                         $urandom_range(9) != 0);
            send_item(CMD_COMPUTE, $urandom, $urandom, 1'($urandom));
         end else begin
            send_item(cmd_type'($urandom_range(3)), $urandom, $urandom, 1'($urandom));
         end
      end
   endtask

   initial begin
      curve_len[0] = 0;
      curve_len[1] = 0;
      seen_count = 0;
      lost_any = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 18;
      recv_idle_pct = 52;
      test_directed();
      test_point_overflow();
      test_hit_overflow();
      test_backpressure();
      send_idle_pct = 52;
      recv_idle_pct = 18;
      test_random(items_sent + 6);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(items_sent + 6);

      wait_drained();
      repeat (500) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
